FILE: hdl/usrq_pkg.sv
// Shared types, sizes and codes for the urgency-sorted record queue.
`default_nettype none

package usrq_pkg;

  // Queue geometry.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MAX_RES  = 16;
  localparam int LCNT_W   = $clog2(MAX_RES);

  // Field widths.
  localparam int TK_W   = 5;
  localparam int AGE_W  = 8;
  localparam int SEX_W  = 2;
  localparam int INS_W  = 2;
  localparam int URG_W  = 3;
  localparam int TAG_W  = 32;
  localparam int KIND_W = 2;
  localparam int ST_W   = 2;
  localparam int REC_W  = TK_W + AGE_W + SEX_W + INS_W + URG_W + TAG_W;
  localparam int DATA_W = ((REC_W + 7) / 8) * 8;
  localparam int PAD_W  = DATA_W - REC_W;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SORT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_BADTICKET = 2'd3;

  // One stored record; the ticket sits in the lowest bits.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [URG_W-1:0] urg;
    logic [INS_W-1:0] ins;
    logic [SEX_W-1:0] sex;
    logic [AGE_W-1:0] age;
    logic [TK_W-1:0]  tk;
  } rec_t;

endpackage

`default_nettype wire

FILE: hdl/urgency_sorted_record_queue.sv
// Urgency-sorted record queue: record memory, sequencer and output register.
//
// Items arrive on the s_axis channel: tuser carries the kind (enqueue,
// dequeue, sort and list, update) and tdata the ticket and record fields.
// Results leave on the m_axis channel with the status in tuser, the record
// in tdata and tlast on the final result of an item.
// One item is worked at a time; s_axis_tready is high only while the
// sequencer is idle. The records live in a 16-entry memory with one write
// port and two registered read ports, and one urgency comparator is reused
// for every pair of the exchange sort.
// Enqueue and the error results go straight to the output step. Dequeue
// reads the head record and then rewrites the tickets of the records behind
// it one slot at a time (a read and a write per slot); update reads the
// stored record and writes it back with the new payload. Sort and list
// reads and compares each of the n*(n-1)/2 pairs for n live records,
// writing both slots back when it exchanges them, then reads and emits
// each listed record in turn.
// Reset empties the queue (head and tail to zero) and drops any result.
// When the receiver stalls, the finished result waits in the output register
// and the sequencer holds before loading the next one, so nothing is lost.
`default_nettype none

module urgency_sorted_record_queue import usrq_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                s_axis_tvalid,
  output logic               s_axis_tready,
  // Fields from bit 0: ticket, age, sex, insurance, urgency, name_tag, zero fill.
  input  wire  [DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: kind.
  input  wire  [KIND_W-1:0]  s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire                m_axis_tready,
  // Fields from bit 0: ticket_out, age_out, sex_out, insurance_out, urgency_out,
  // name_tag_out, zero fill.
  output logic [DATA_W-1:0]  m_axis_tdata,
  // Fields from bit 0: status.
  output logic [ST_W-1:0]    m_axis_tuser,
  output logic               m_axis_tlast
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_DEQ_GET = 11'b000_0000_0010,
    S_REN_RD  = 11'b000_0000_0100,
    S_REN_WR  = 11'b000_0000_1000,
    S_UPD_WR  = 11'b000_0001_0000,
    S_SRT_RD  = 11'b000_0010_0000,
    S_SRT_CMP = 11'b000_0100_0000,
    S_SRT_SWJ = 11'b000_1000_0000,
    S_LST_RD  = 11'b001_0000_0000,
    S_LST_GET = 11'b010_0000_0000,
    S_EMIT    = 11'b100_0000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   i_q, i_d;
  logic [CNT_W-1:0]   j_q, j_d;
  logic [LCNT_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]   upd_idx_q, upd_idx_d;
  rec_t               req_q, req_d;
  rec_t               pend_rec_q, pend_rec_d;
  logic [ST_W-1:0]    pend_st_q, pend_st_d;
  logic               pend_last_q, pend_last_d;
  logic               out_valid_q, out_valid_d;
  rec_t               out_rec_q, out_rec_d;
  logic [ST_W-1:0]    out_st_q, out_st_d;
  logic               out_last_q, out_last_d;

  rec_t               mem_q [CAPACITY];
  rec_t               rd_a_q, rd_b_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_a_addr, rd_b_addr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  rec_t               wdata;

  rec_t               in_rec;
  logic               accept;
  logic               empty;
  logic               swap;
  logic               out_free;

  assign in_rec   = rec_t'(s_axis_tdata[REC_W-1:0]);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign empty    = (head_q == tail_q);
  assign out_free = !out_valid_q || m_axis_tready;
  // The shared comparator: lower urgency at the earlier slot means exchange.
  assign swap     = (rd_a_q.urg < rd_b_q.urg);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_rec_q};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

  // Sequencer: next state, counters, memory port control, pending result and output register.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    upd_idx_d   = upd_idx_q;
    req_d       = req_q;
    pend_rec_d  = pend_rec_q;
    pend_st_d   = pend_st_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_rec_d   = out_rec_q;
    out_st_d    = out_st_q;
    out_last_d  = out_last_q;
    rd_en       = 1'b0;
    rd_a_addr   = head_q[IDX_W-1:0];
    rd_b_addr   = j_q[IDX_W-1:0];
    we          = 1'b0;
    waddr       = i_q[IDX_W-1:0];
    wdata       = rd_a_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d       = in_rec;
          pend_rec_d  = '0;
          pend_last_d = 1'b1;
          state_d     = S_EMIT;
          case (s_axis_tuser)
            KIND_ENQ: begin
              if (32'(tail_q) >= CAPACITY) begin
                pend_st_d = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = tail_q[IDX_W-1:0];
                wdata      = in_rec;
                wdata.tk   = TK_W'(tail_q + 1'b1);
                tail_d     = tail_q + 1'b1;
                pend_st_d  = ST_OK;
                pend_rec_d = wdata;
              end
            end
            KIND_DEQ: begin
              if (empty) begin
                pend_st_d = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_a_addr = head_q[IDX_W-1:0];
                state_d   = S_DEQ_GET;
              end
            end
            KIND_SORT: begin
              if (empty) begin
                pend_st_d = ST_EMPTY;
              end else if (head_q + 1'b1 < tail_q) begin
                i_d     = head_q;
                j_d     = head_q + 1'b1;
                state_d = S_SRT_RD;
              end else begin
                i_d     = head_q;
                k_d     = '0;
                state_d = S_LST_RD;
              end
            end
            default: begin
              if (empty) begin
                pend_st_d = ST_EMPTY;
              end else if (in_rec.tk == '0 || 32'(in_rec.tk) > 32'(tail_q)
                           || 32'(in_rec.tk) > CAPACITY) begin
                pend_st_d = ST_BADTICKET;
              end else begin
                upd_idx_d = IDX_W'(in_rec.tk - 1'b1);
                rd_en     = 1'b1;
                rd_a_addr = IDX_W'(in_rec.tk - 1'b1);
                state_d   = S_UPD_WR;
              end
            end
          endcase
        end
      end

      // Head record is read; remaining slots get fresh tickets.
      S_DEQ_GET: begin
        pend_st_d   = ST_OK;
        pend_rec_d  = rd_a_q;
        pend_last_d = 1'b1;
        head_d      = head_q + 1'b1;
        i_d         = head_q + 1'b1;
        state_d     = (head_q + 1'b1 < tail_q) ? S_REN_RD : S_EMIT;
      end

      S_REN_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = i_q[IDX_W-1:0];
        state_d   = S_REN_WR;
      end

      S_REN_WR: begin
        we       = 1'b1;
        waddr    = i_q[IDX_W-1:0];
        wdata    = rd_a_q;
        wdata.tk = TK_W'(i_q + 1'b1);
        i_d      = i_q + 1'b1;
        state_d  = (i_q + 1'b1 < tail_q) ? S_REN_RD : S_EMIT;
      end

      // Update keeps the stored ticket and takes the new payload.
      S_UPD_WR: begin
        we          = 1'b1;
        waddr       = upd_idx_q;
        wdata       = req_q;
        wdata.tk    = rd_a_q.tk;
        pend_st_d   = ST_OK;
        pend_rec_d  = wdata;
        pend_last_d = 1'b1;
        state_d     = S_EMIT;
      end

      S_SRT_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = i_q[IDX_W-1:0];
        rd_b_addr = j_q[IDX_W-1:0];
        state_d   = S_SRT_CMP;
      end

      S_SRT_CMP, S_SRT_SWJ: begin
        if (state_q == S_SRT_CMP && swap) begin
          // First half of the exchange: later record moves to slot i.
          we      = 1'b1;
          waddr   = i_q[IDX_W-1:0];
          wdata   = rd_b_q;
          state_d = S_SRT_SWJ;
        end else begin
          if (state_q == S_SRT_SWJ) begin
            we    = 1'b1;
            waddr = j_q[IDX_W-1:0];
            wdata = rd_a_q;
          end
          // Step to the next pair, or start the listing.
          if (j_q + 1'b1 < tail_q) begin
            j_d     = j_q + 1'b1;
            state_d = S_SRT_RD;
          end else if (i_q + 2'd2 < tail_q) begin
            i_d     = i_q + 1'b1;
            j_d     = i_q + 2'd2;
            state_d = S_SRT_RD;
          end else begin
            i_d     = head_q;
            k_d     = '0;
            state_d = S_LST_RD;
          end
        end
      end

      S_LST_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = i_q[IDX_W-1:0];
        state_d   = S_LST_GET;
      end

      S_LST_GET: begin
        pend_st_d   = ST_OK;
        pend_rec_d  = rd_a_q;
        pend_last_d = (i_q + 1'b1 == tail_q) || (32'(k_q) == MAX_RES - 1);
        i_d         = i_q + 1'b1;
        k_d         = k_q + 1'b1;
        state_d     = S_EMIT;
      end

      // Hand the pending result to the output register once it is free.
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rec_d   = pend_rec_q;
          out_st_d    = pend_st_q;
          out_last_d  = pend_last_q;
          state_d     = pend_last_q ? S_IDLE : S_LST_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Record memory with one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_a_addr];
      rd_b_q <= mem_q[rd_b_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    upd_idx_q   <= upd_idx_d;
    req_q       <= req_d;
    pend_rec_q  <= pend_rec_d;
    pend_st_q   <= pend_st_d;
    pend_last_q <= pend_last_d;
    out_rec_q   <= out_rec_d;
    out_st_q    <= out_st_d;
    out_last_q  <= out_last_d;
  end

endmodule

`default_nettype wire
